FILE: hw/rtl/bdpl_pkg.sv
package bdpl_pkg;

   // Number of button channels served by the block.
   localparam int CHANNELS = 3;

   // Widths fixed by the item format.
   localparam int ACTION_WIDTH  = 2;
   localparam int CHANNEL_WIDTH = 2;
   localparam int RAW_WIDTH     = 3;
   localparam int TIME_WIDTH    = 32;
   localparam int DEB_WIDTH     = 16;
   localparam int REQ_DATA_WIDTH = 40;
   localparam int REQ_USER_WIDTH = 4;
   localparam int RSP_DATA_WIDTH = 8;

   localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = 16'd20;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_TAKE    = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_UNUSED  = 2'd3
   } action_type;

   // Command broadcast to every lane for one accepted item.
   typedef struct packed {
      logic                  load;
      action_type            action;
      logic [TIME_WIDTH-1:0] now_ms;
      logic [DEB_WIDTH-1:0]  debounce_ms;
   } lane_cmd_type;

   // What a lane reports after applying the item.
   typedef struct packed {
      logic stable;
      logic pending;
      logic taken;
   } lane_status_type;

endpackage

FILE: hw/rtl/button_debounce_press_latch.sv
// A response shows on the rsp side in the cycle after its item is accepted.
// Throughput: one item per cycle unless rsp stalls; every channel lane updates
// in the same cycle; the single response register frees once its response is taken.
// Reset: synchronous, active high; all lanes return to released and clear,
// timestamps to zero, and the debounce interval to 20 ms.
module button_debounce_press_latch (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // raw_levels [2:0], now_ms [34:3], zero fill [39:35]
   input  logic [bdpl_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // action [1:0], channel [3:2]
   input  logic [bdpl_pkg::REQ_USER_WIDTH-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // press_taken [0], stable_levels [3:1], pending_flags [6:4], zero fill [7]
   output logic [bdpl_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_wen,
   input  logic [bdpl_pkg::DEB_WIDTH-1:0]        csr_wdata
);
   import bdpl_pkg::*;

   logic [DEB_WIDTH-1:0]     debounce_ff, debounce_in;
   logic                     accept;
   logic [CHANNEL_WIDTH-1:0] channel;
   logic [RAW_WIDTH-1:0]     raw_levels;
   lane_cmd_type             cmd;
   lane_status_type          lane_status [CHANNELS];

   assign debounce_in = csr_wen ? csr_wdata : debounce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else begin
         debounce_ff <= debounce_in;
      end
   end

   // The response register can reload in the same cycle it is drained.
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign channel         = req_tuser[ACTION_WIDTH +: CHANNEL_WIDTH];
   assign raw_levels      = req_tdata[RAW_WIDTH-1:0];
   assign cmd.load        = accept;
   assign cmd.action      = action_type'(req_tuser[ACTION_WIDTH-1:0]);
   assign cmd.now_ms      = req_tdata[RAW_WIDTH +: TIME_WIDTH];
   assign cmd.debounce_ms = debounce_ff;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic raw_bit;
      logic hit;

      if (i < RAW_WIDTH) begin : g_raw
         assign raw_bit = raw_levels[i];
      end else begin : g_noraw
         assign raw_bit = 1'b0;
      end

      assign hit = (int'(channel) == i);

      bdpl_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .hit       (hit),
         .raw_level (raw_bit),
         .status    (lane_status[i])
      );
   end

   bdpl_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .lane_status (lane_status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: hw/rtl/bdpl_lane.sv
module bdpl_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  bdpl_pkg::lane_cmd_type     cmd,
   input  logic                       hit,
   input  logic                       raw_level,
   output bdpl_pkg::lane_status_type  status
);
   import bdpl_pkg::*;

   logic                  sampled_ff, sampled_in;
   logic [TIME_WIDTH-1:0] change_time_ff, change_time_in;
   logic                  stable_ff, stable_in;
   logic                  pending_ff, pending_in;
   logic                  release_ff, release_in;
   logic                  taken;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  settled;

   // Wrap-safe age of the current raw level.
   assign elapsed = cmd.now_ms - change_time_ff;
   assign settled = elapsed >= {{(TIME_WIDTH-DEB_WIDTH){1'b0}}, cmd.debounce_ms};

   always_comb begin
      sampled_in     = sampled_ff;
      change_time_in = change_time_ff;
      stable_in      = stable_ff;
      pending_in     = pending_ff;
      release_in     = release_ff;
      taken          = 1'b0;
      if (cmd.load) begin
         unique case (cmd.action)
            ACT_SAMPLE: begin
               if (raw_level != sampled_ff) begin
                  // A level change only restarts the hold timer.
                  sampled_in     = raw_level;
                  change_time_in = cmd.now_ms;
               end else if (settled) begin
                  if (raw_level != stable_ff) begin
                     stable_in = raw_level;
                     if (raw_level && !release_ff) begin
                        pending_in = 1'b1;
                     end
                  end
                  if (!raw_level) begin
                     release_in = 1'b0;
                  end
               end
            end
            ACT_TAKE: begin
               if (hit && pending_ff) begin
                  pending_in = 1'b0;
                  taken      = 1'b1;
               end
            end
            ACT_RELEASE: begin
               if (hit) begin
                  pending_in = 1'b0;
                  release_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff     <= 1'b0;
         change_time_ff <= '0;
         stable_ff      <= 1'b0;
         pending_ff     <= 1'b0;
         release_ff     <= 1'b0;
      end else begin
         sampled_ff     <= sampled_in;
         change_time_ff <= change_time_in;
         stable_ff      <= stable_in;
         pending_ff     <= pending_in;
         release_ff     <= release_in;
      end
   end

   // Status reflects the state after this item, as the response needs it.
   assign status.stable  = stable_in;
   assign status.pending = pending_in;
   assign status.taken   = taken;

endmodule

FILE: hw/rtl/bdpl_merge.sv
module bdpl_merge (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  bdpl_pkg::lane_status_type                lane_status [bdpl_pkg::CHANNELS],
   input  logic                                     rsp_tready,
   output logic                                     rsp_tvalid,
   output logic [bdpl_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata
);
   import bdpl_pkg::*;

   logic                      valid_ff, valid_in;
   logic [RSP_DATA_WIDTH-1:0] data_ff, data_in;
   logic                      taken_any;
   logic [RAW_WIDTH-1:0]      stable_bits;
   logic [RAW_WIDTH-1:0]      pending_bits;

   always_comb begin
      taken_any = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         taken_any = taken_any | lane_status[i].taken;
      end
   end

   // Only the channels that have a bit in the response are shown.
   for (genvar b = 0; b < RAW_WIDTH; b++) begin : g_bits
      if (b < CHANNELS) begin : g_lane
         assign stable_bits[b]  = lane_status[b].stable;
         assign pending_bits[b] = lane_status[b].pending;
      end else begin : g_none
         assign stable_bits[b]  = 1'b0;
         assign pending_bits[b] = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = {{(RSP_DATA_WIDTH-2*RAW_WIDTH-1){1'b0}}, pending_bits, stable_bits,
                     taken_any};
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: hw/rtl/bdpl_checker.sv
module bdpl_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [bdpl_pkg::REQ_USER_WIDTH-1:0]   req_tuser,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [bdpl_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata
);
   import bdpl_pkg::*;

   logic req_accept;
   logic is_take;

   assign req_accept = req_tvalid && req_tready;
   assign is_take    = req_tuser[ACTION_WIDTH-1:0] == ACT_TAKE;

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Every accepted item shows up as a response in the next cycle.
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted item produced no response");

   // With the response register empty the block must take an item.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while response register empty");

   // Only a take item can report a consumed press.
   a_taken_take: assert property (@(posedge clock) disable iff (reset)
      req_accept && !is_take |=> !rsp_tdata[0])
      else $error("press reported taken for a non-take item");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind button_debounce_press_latch bdpl_checker u_bdpl_checker (.*);

FILE: verif/button_debounce_press_latch_tb.sv
module button_debounce_press_latch_tb;
   import bdpl_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 165;
   localparam int REPORT_LIMIT = 10;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      action_type       action;
      logic [1:0]       channel;
      logic [2:0]       raw;
      logic [31:0]      now;
   } btn_cmd_type;

   typedef struct packed {
      logic             taken;
      logic [2:0]       stable;
      logic [2:0]       pending;
   } btn_status_type;

   typedef struct packed {
      btn_cmd_type      cmd;
      logic             fixed;
      btn_status_type   want;
   } dir_row_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata = '0;
   logic [REQ_USER_WIDTH-1:0]   req_tuser = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic                        csr_wen = 1'b0;
   logic [DEB_WIDTH-1:0]        csr_wdata = '0;

   // Predictor state, one entry per channel.
   logic                        seen_lvl  [CHANNELS];
   logic [31:0]                 seen_at   [CHANNELS];
   logic                        settled   [CHANNELS];
   logic                        latched   [CHANNELS];
   logic                        rel_req   [CHANNELS];
   logic [DEB_WIDTH-1:0]        hold_ms;

   btn_status_type              status_q [$];
   int                          mismatches = 0;
   int                          cycle_count = 0;
   int                          burst_left = 0;
   logic [2:0]                  cur_raw;
   logic [31:0]                 stamp;

   // Held press on all, wrap-around timing, glitches and the ignored cases.
   dir_row_type dir_rows [25] = '{
      '{'{ACT_TAKE,    2'd0, 3'd0, 32'h0000_0000}, 1'b1, '{1'b0, 3'd0, 3'd0}},
      '{'{ACT_SAMPLE,  2'd3, 3'd7, 32'h0000_0000}, 1'b1, '{1'b0, 3'd0, 3'd0}},
      '{'{ACT_SAMPLE,  2'd0, 3'd7, 32'h0000_0013}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd7, 32'h0000_0014}, 1'b0, '0},
      '{'{ACT_TAKE,    2'd0, 3'd0, 32'h0000_0000}, 1'b0, '0},
      '{'{ACT_TAKE,    2'd0, 3'd0, 32'h0000_0000}, 1'b0, '0},
      '{'{ACT_TAKE,    2'd3, 3'd7, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 3'd7, 3'd6}},
      '{'{ACT_RELEASE, 2'd3, 3'd0, 32'h0000_0000}, 1'b1, '{1'b0, 3'd7, 3'd6}},
      '{'{ACT_RELEASE, 2'd1, 3'd0, 32'h0000_0000}, 1'b0, '0},
      '{'{ACT_UNUSED,  2'd2, 3'd0, 32'h0000_0000}, 1'b1, '{1'b0, 3'd7, 3'd4}},
      '{'{ACT_SAMPLE,  2'd0, 3'd0, 32'h0000_0064}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd0, 32'h0000_0077}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd0, 32'h0000_0078}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd5, 32'hFFFF_FFF0}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd5, 32'h0000_0004}, 1'b0, '0},
      '{'{ACT_RELEASE, 2'd2, 3'd0, 32'h0000_0000}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd1, 32'h0000_0010}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd5, 32'h0000_0020}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd5, 32'h0000_0040}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd1, 32'h0000_0050}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd1, 32'h0000_0070}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd5, 32'h0000_0080}, 1'b0, '0},
      '{'{ACT_SAMPLE,  2'd0, 3'd5, 32'h0000_0094}, 1'b0, '0},
      '{'{ACT_TAKE,    2'd2, 3'd0, 32'h0000_0000}, 1'b0, '0},
      '{'{ACT_TAKE,    2'd1, 3'd7, 32'hFFFF_FFFF}, 1'b0, '0}
   };

   button_debounce_press_latch dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_buttons();
      for (int i = 0; i < CHANNELS; i++) begin
         seen_lvl[i] = 1'b0;
         seen_at[i]  = '0;
         settled[i]  = 1'b0;
         latched[i]  = 1'b0;
         rel_req[i]  = 1'b0;
      end
      hold_ms = DEBOUNCE_RESET;
   endfunction

   // Applies one item to the predicted buttons and returns the status it reports.
   function automatic btn_status_type debounce_apply(btn_cmd_type c);
      btn_status_type s;
      logic           lvl;
      logic [31:0]    held;
      s = '0;
      case (c.action)
         ACT_SAMPLE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               lvl  = (i < 3) ? c.raw[i] : 1'b0;
               held = c.now - seen_at[i];
               if (lvl != seen_lvl[i]) begin
                  seen_lvl[i] = lvl;
                  seen_at[i]  = c.now;
               end else if (held >= {16'd0, hold_ms}) begin
                  if (lvl != settled[i]) begin
                     settled[i] = lvl;
                     if (lvl && !rel_req[i])
                        latched[i] = 1'b1;
                  end
                  if (!lvl)
                     rel_req[i] = 1'b0;
               end
            end
         end
         ACT_TAKE: begin
            if (c.channel < CHANNELS && latched[c.channel]) begin
               latched[c.channel] = 1'b0;
               s.taken = 1'b1;
            end
         end
         ACT_RELEASE: begin
            if (c.channel < CHANNELS) begin
               latched[c.channel] = 1'b0;
               rel_req[c.channel] = 1'b1;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < CHANNELS && i < 3; i++) begin
         s.stable[i]  = settled[i];
         s.pending[i] = latched[i];
      end
      return s;
   endfunction

   // Mostly well-formed samples with levels held across time steps around the
   // debounce interval, plus commands and some noise with arbitrary fields.
   function automatic btn_cmd_type random_cmd();
      btn_cmd_type c;
      int unsigned pick;
      int unsigned hold;
      logic [31:0] step;
      pick = $urandom_range(0, 99);
      hold = {16'd0, hold_ms};
      c.action  = ACT_SAMPLE;
      c.channel = 2'($urandom_range(0, 3));
      c.raw     = 3'($urandom_range(0, 7));
      c.now     = $urandom;
      if (pick < 4) begin
         c.action = ACT_UNUSED;
      end else if (pick < 8) begin
         stamp   = c.now;
         cur_raw = c.raw;
      end else if (pick < 70) begin
         if ($urandom_range(0, 3) == 0)
            cur_raw = cur_raw ^ 3'($urandom_range(1, 7));
         case ($urandom_range(0, 5))
            0: step = 0;
            1: step = $urandom_range(0, hold / 2);
            2: step = (hold == 0) ? 0 : hold - 1;
            3: step = hold;
            4: step = hold + $urandom_range(1, 5);
            default: step = $urandom_range(0, 4 * hold + 3);
         endcase
         stamp = stamp + step;
         c.raw = cur_raw;
         c.now = stamp;
      end else if (pick < 85) begin
         c.action = ACT_TAKE;
      end else begin
         c.action = ACT_RELEASE;
      end
      return c;
   endfunction

   task automatic send_cmd(input btn_cmd_type c, input logic fixed,
                           input btn_status_type want);
      int             gap;
      btn_status_type calc;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, c.now, c.raw};
      req_tuser  <= {c.channel, c.action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      calc = debounce_apply(c);
      status_q.push_back(fixed ? want : calc);
   endtask

   task automatic drain_and_set_hold(input logic [DEB_WIDTH-1:0] value);
      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      hold_ms = value;
      burst_left = 0;
      cur_raw = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 0)
         stamp = 32'hFFFF_FFFF - $urandom_range(0, 4 * value);
      else
         stamp = $urandom;
   endtask

   // Receiver alternates between stretches that are always ready, randomly
   // ready, and mostly stalled.
   int rsp_mode = 0;
   int rsp_left = 0;
   always @(posedge clock) begin
      if (rsp_left == 0) begin
         rsp_mode <= $urandom_range(0, 2);
         rsp_left <= $urandom_range(10, 60);
      end else begin
         rsp_left <= rsp_left - 1;
      end
      case (rsp_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      btn_status_type got;
      btn_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[3:1], rsp_tdata[6:4]};
         if (status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected item on rsp: taken=%0b stable=%03b pending=%03b",
                        got.taken, got.stable, got.pending);
         end else begin
            want = status_q.pop_front();
            if (got.taken != want.taken || got.stable != want.stable ||
                got.pending != want.pending) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"rsp mismatch: taken exp %0b got %0b, stable exp %03b got %03b,",
                            " pending exp %03b got %03b"},
                           want.taken, got.taken, want.stable, got.stable,
                           want.pending, got.pending);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   logic [DEB_WIDTH-1:0] hold_plan [6];

   initial begin
      clear_buttons();
      hold_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd7, 16'($urandom_range(2, 400)), 16'd20};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r])
         send_cmd(dir_rows[r].cmd, dir_rows[r].fixed, dir_rows[r].want);

      foreach (hold_plan[p]) begin
         drain_and_set_hold(hold_plan[p]);
         repeat (PHASE_ITEMS)
            send_cmd(random_cmd(), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
